/* hw/rtl/aikl_pkg.sv */
// Shared types and constants for the alcohol interlock keypad lock.
package aikl_pkg;

  localparam int DEFAULT_CODE_LENGTH = 5;

  localparam logic [3:0] ENTER_KEY      = 4'd10;
  localparam logic [3:0] MENU_UNLOCK    = 4'd1;
  localparam logic [3:0] MENU_THRESHOLD = 4'd2;
  localparam logic [3:0] MENU_NEWCODE   = 4'd3;

  localparam logic [7:0] THRESHOLD_RESET = 8'd44;

  typedef enum logic [2:0] {
    PH_UNLOCKED = 3'd0,
    PH_ENTRY    = 3'd1,
    PH_MENU     = 3'd2,
    PH_TENS     = 3'd3,
    PH_UNITS    = 3'd4,
    PH_NEWCODE  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    EV_LEVEL   = 3'd0,
    EV_KEY     = 3'd1,
    EV_WRONG   = 3'd2,
    EV_MENU    = 3'd3,
    EV_UNLOCK  = 3'd4,
    EV_THRESH  = 3'd5,
    EV_CODESET = 3'd6,
    EV_BADOPT  = 3'd7
  } event_t;

  typedef struct packed {
    logic [6:0] level_percent;
    logic       alarm_lamp;
    logic       ok_lamp;
    logic       release_lamp;
    logic       locked;
    event_t     event_code;
  } result_t;

endpackage

/* hw/rtl/aikl_level.sv */
// Sensor sample to level percentage, floor(sample * 100 / 1023).
module aikl_level (
  input  logic [9:0] sample,
  output logic [6:0] level
);

  localparam int LEVEL_SCALE = 100;
  localparam int FULL_SCALE  = 1023;

  logic [16:0] product;
  logic [6:0]  quot_low;
  logic [10:0] remainder;

  always_comb begin
    product   = 17'(sample) * 17'(LEVEL_SCALE);
    quot_low  = product[16:10];
    remainder = 11'(product[9:0]) + 11'(quot_low);
    level     = quot_low + 7'(remainder >= 11'(FULL_SCALE));
  end

endmodule

/* hw/rtl/aikl_ctrl.sv */
// Lock state machine, code and threshold storage, and result formation.
module aikl_ctrl #(
  parameter int CODE_LENGTH = aikl_pkg::DEFAULT_CODE_LENGTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              mode,
  input  logic [3:0]        key,
  input  logic [6:0]        level,
  output aikl_pkg::result_t res
);
  import aikl_pkg::*;

  localparam int CNT_W = $clog2(CODE_LENGTH + 1);
  localparam logic [CNT_W-1:0] CODE_LEN = CNT_W'(CODE_LENGTH);

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] key_count, key_count_next;
  logic [3:0]       entered_keys [CODE_LENGTH];
  logic [3:0]       entered_keys_next [CODE_LENGTH];
  logic [3:0]       stored_code [CODE_LENGTH];
  logic [3:0]       stored_code_next [CODE_LENGTH];
  logic [7:0]       threshold, threshold_next;
  logic [3:0]       threshold_tens, threshold_tens_next;
  logic [6:0]       level_reg, level_reg_next;
  logic             alarm, alarm_next;
  logic             ok, ok_next;
  logic             released, released_next;
  event_t           ev;
  logic             code_match;

  always_comb begin
    code_match = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (entered_keys[i] != stored_code[i]) begin
        code_match = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_UNLOCKED;
      key_count      <= '0;
      threshold      <= THRESHOLD_RESET;
      threshold_tens <= '0;
      level_reg      <= '0;
      alarm          <= 1'b0;
      ok             <= 1'b0;
      released       <= 1'b0;
      for (int i = 0; i < CODE_LENGTH; i++) begin
        entered_keys[i] <= '0;
        stored_code[i]  <= 4'(i + 1);
      end
    end else if (en) begin
      phase          <= phase_next;
      key_count      <= key_count_next;
      threshold      <= threshold_next;
      threshold_tens <= threshold_tens_next;
      level_reg      <= level_reg_next;
      alarm          <= alarm_next;
      ok             <= ok_next;
      released       <= released_next;
      entered_keys   <= entered_keys_next;
      stored_code    <= stored_code_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    key_count_next      = key_count;
    threshold_next      = threshold;
    threshold_tens_next = threshold_tens;
    level_reg_next      = level_reg;
    alarm_next          = alarm;
    ok_next             = ok;
    released_next       = released;
    entered_keys_next   = entered_keys;
    stored_code_next    = stored_code;
    ev                  = EV_LEVEL;

    if (!mode) begin
      level_reg_next = level;
      if (phase == PH_UNLOCKED) begin
        if ({1'b0, level} > threshold) begin
          alarm_next     = 1'b1;
          ok_next        = 1'b0;
          phase_next     = PH_ENTRY;
          key_count_next = '0;
        end else begin
          alarm_next = 1'b0;
          ok_next    = 1'b1;
        end
      end
    end else begin
      unique case (phase)
        PH_ENTRY: begin
          if (key_count < CODE_LEN) begin
            for (int i = 0; i < CODE_LENGTH; i++) begin
              if (key_count == CNT_W'(i)) begin
                entered_keys_next[i] = key;
              end
            end
            key_count_next = key_count + CNT_W'(1);
            ev             = EV_KEY;
          end else if (key == ENTER_KEY && code_match) begin
            phase_next     = PH_MENU;
            key_count_next = '0;
            ev             = EV_MENU;
          end else begin
            phase_next     = PH_ENTRY;
            key_count_next = '0;
            ev             = EV_WRONG;
          end
        end
        PH_MENU: begin
          if (key == MENU_UNLOCK) begin
            phase_next     = PH_UNLOCKED;
            key_count_next = '0;
            released_next  = 1'b1;
            ev             = EV_UNLOCK;
          end else if (key == MENU_THRESHOLD) begin
            phase_next = PH_TENS;
            ev         = EV_KEY;
          end else if (key == MENU_NEWCODE) begin
            phase_next     = PH_NEWCODE;
            key_count_next = '0;
            ev             = EV_KEY;
          end else begin
            phase_next     = PH_ENTRY;
            key_count_next = '0;
            ev             = EV_BADOPT;
          end
        end
        PH_TENS: begin
          threshold_tens_next = key;
          phase_next          = PH_UNITS;
          ev                  = EV_KEY;
        end
        PH_UNITS: begin
          threshold_next = 8'({threshold_tens, 3'b000}) + 8'({threshold_tens, 1'b0})
                         + 8'(key);
          phase_next     = PH_ENTRY;
          key_count_next = '0;
          ev             = EV_THRESH;
        end
        PH_NEWCODE: begin
          if (key_count < CODE_LEN) begin
            for (int i = 0; i < CODE_LENGTH; i++) begin
              if (key_count == CNT_W'(i)) begin
                stored_code_next[i] = key;
              end
            end
            key_count_next = key_count + CNT_W'(1);
          end
          if (key_count_next >= CODE_LEN) begin
            phase_next     = PH_ENTRY;
            key_count_next = '0;
            ev             = EV_CODESET;
          end else begin
            ev = EV_KEY;
          end
        end
        PH_UNLOCKED: begin
        end
        default: begin
        end
      endcase
    end

    res.level_percent = level_reg_next;
    res.alarm_lamp    = alarm_next;
    res.ok_lamp       = ok_next;
    res.release_lamp  = released_next;
    res.locked        = (phase_next != PH_UNLOCKED);
    res.event_code    = ev;
  end

  a_release_sticky: assert property (@(posedge clk) disable iff (rst)
    released |=> released)
    else $error("release lamp dropped");

  a_lamps_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(alarm && ok))
    else $error("alarm and ok lamps both set");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    key_count <= CODE_LEN)
    else $error("key count beyond code length");

  a_overlimit_locks: assert property (@(posedge clk) disable iff (rst)
    en && !mode && phase == PH_UNLOCKED && {1'b0, level} > threshold
    |=> phase == PH_ENTRY && alarm)
    else $error("over-limit sample did not lock");

endmodule

/* hw/rtl/alcohol_interlock_keypad_lock.sv */
// Top level of the alcohol interlock keypad lock: stream ports and item registers.
//
// Every request on the input stream produces exactly one result on the output
// stream. An item is registered on entry, the level conversion and the lock
// state update are computed combinationally from that register, and the result
// lands in an output register, so the block sustains one item per clock cycle
// while m_tready does not hold back a result. A result waiting on m_tready
// stalls the pipeline but the input register still takes a request while the
// output register is full and the input register is empty. Samples are
// converted to floor(sample * 100 / 1023); keys drive the code entry and menu.
// After reset the block is unlocked, the code is 1,2,3,4,5 and the threshold is 44.
module alcohol_interlock_keypad_lock #(
  parameter int CODE_LENGTH = aikl_pkg::DEFAULT_CODE_LENGTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // sample[9:0], key[13:10], zero[15:14]
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // level_percent[6:0], alarm_lamp[7], ok_lamp[8],
                                 // release_lamp[9], locked[10], zero[15:11]
  output logic [2:0]  m_tuser    // event_code
);
  import aikl_pkg::*;

  logic       in_valid;
  logic       in_mode;
  logic [9:0] in_sample;
  logic [3:0] in_key;
  logic       advance;
  logic       step;
  logic [6:0] level;
  result_t    res;
  result_t    res_q;
  logic       out_valid;

  assign advance  = !out_valid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode   <= s_tuser;
      in_sample <= s_tdata[9:0];
      in_key    <= s_tdata[13:10];
    end
  end

  aikl_level u_level (
    .sample (in_sample),
    .level  (level)
  );

  aikl_ctrl #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .en    (step),
    .mode  (in_mode),
    .key   (in_key),
    .level (level),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b00000, res_q.locked, res_q.release_lamp, res_q.ok_lamp,
                     res_q.alarm_lamp, res_q.level_percent};
  assign m_tuser  = res_q.event_code;

endmodule
